@@ design/mab_pkg.sv @@
// shared types, codes and constants of the 6502 alu and branch block
package mab_pkg;

    // operation codes of the mode field
    localparam logic [2:0] MODE_AND    = 3'd0;
    localparam logic [2:0] MODE_ADC    = 3'd1;
    localparam logic [2:0] MODE_SBC    = 3'd2;
    localparam logic [2:0] MODE_CLC    = 3'd3;
    localparam logic [2:0] MODE_CLD    = 3'd4;
    localparam logic [2:0] MODE_BRANCH = 3'd5;

    // branch condition codes
    localparam logic [2:0] COND_BPL = 3'd0;
    localparam logic [2:0] COND_BMI = 3'd1;
    localparam logic [2:0] COND_BVC = 3'd2;
    localparam logic [2:0] COND_BVS = 3'd3;
    localparam logic [2:0] COND_BCC = 3'd4;
    localparam logic [2:0] COND_BCS = 3'd5;
    localparam logic [2:0] COND_BNE = 3'd6;
    localparam logic [2:0] COND_BEQ = 3'd7;

    // status bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_D = 3;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] STATUS_RESET = 8'h20;

    localparam logic [1:0] EXTRA_NONE  = 2'd0;
    localparam logic [1:0] EXTRA_TAKEN = 2'd1;
    localparam logic [1:0] EXTRA_PAGE  = 2'd2;

    typedef struct packed {
        logic [2:0]        mode;
        logic [7:0]        operand;
        logic [2:0]        branch_cond;
        logic signed [7:0] rel_offset;
        logic [15:0]       next_pc;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  accumulator;
        logic [7:0]  flags;
        logic [15:0] new_pc;
        logic [1:0]  extra_cycles;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_AND,
        OP_ADD,
        OP_CLC,
        OP_CLD,
        OP_BRANCH,
        OP_NOP
    } t_op;

    // decoded command passed from front to back
    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [2:0]  cond;
        logic [15:0] next_pc;
        logic [15:0] target;
        logic        page_cross;
    } t_cmd;

endpackage

@@ design/mab_front.sv @@
// front stage: takes input items, decodes them and precomputes branch targets
module mab_front
    import mab_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  [15:0] ext_offset;

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    assign ext_offset = {{8{i_in_item.rel_offset[7]}}, i_in_item.rel_offset};

    always_comb begin
        n_cmd.data       = i_in_item.operand;
        n_cmd.cond       = i_in_item.branch_cond;
        n_cmd.next_pc    = i_in_item.next_pc;
        n_cmd.target     = i_in_item.next_pc + ext_offset;
        n_cmd.page_cross = n_cmd.target[15:8] != i_in_item.next_pc[15:8];
        case (i_in_item.mode)
            MODE_AND:    n_cmd.op = OP_AND;
            MODE_ADC:    n_cmd.op = OP_ADD;
            MODE_SBC: begin
                // subtract is add of the inverted operand
                n_cmd.op   = OP_ADD;
                n_cmd.data = ~i_in_item.operand;
            end
            MODE_CLC:    n_cmd.op = OP_CLC;
            MODE_CLD:    n_cmd.op = OP_CLD;
            MODE_BRANCH: n_cmd.op = OP_BRANCH;
            default:     n_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ design/mab_queue.sv @@
// two-entry command queue between front and back
module mab_queue
    import mab_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_cmd i_wr_cmd,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_cmd o_rd_cmd
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_wr_ready = r_count != 2'd2;
    assign o_rd_valid = r_count != 2'd0;
    assign o_rd_cmd   = r_mem[r_rptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_wr_cmd;
        end
    end

endmodule

@@ design/mab_back.sv @@
// back stage: executes commands against accumulator and status, drives the result register
module mab_back
    import mab_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      [7:0] r_acc;
    logic      [7:0] r_status;
    logic            r_out_valid;
    t_out_item       r_out;

    logic      [7:0] n_acc;
    logic      [7:0] n_status;
    t_out_item       n_out;
    logic      [8:0] sum;
    logic            taken;
    logic            exec;

    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign exec        = i_cmd_valid && o_cmd_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign sum = {1'b0, r_acc} + {1'b0, i_cmd.data} + {8'd0, r_status[FLAG_C]};

    always_comb begin
        case (i_cmd.cond)
            COND_BPL: taken = !r_status[FLAG_N];
            COND_BMI: taken =  r_status[FLAG_N];
            COND_BVC: taken = !r_status[FLAG_V];
            COND_BVS: taken =  r_status[FLAG_V];
            COND_BCC: taken = !r_status[FLAG_C];
            COND_BCS: taken =  r_status[FLAG_C];
            COND_BNE: taken = !r_status[FLAG_Z];
            COND_BEQ: taken =  r_status[FLAG_Z];
            default:  taken = 1'b0;
        endcase
    end

    always_comb begin
        n_acc              = r_acc;
        n_status           = r_status;
        n_out.new_pc       = i_cmd.next_pc;
        n_out.extra_cycles = EXTRA_NONE;
        case (i_cmd.op)
            OP_AND: begin
                n_acc            = r_acc & i_cmd.data;
                n_status[FLAG_Z] = n_acc == 8'd0;
                n_status[FLAG_N] = n_acc[7];
            end
            OP_ADD: begin
                n_acc            = sum[7:0];
                n_status[FLAG_C] = sum[8];
                n_status[FLAG_Z] = sum[7:0] == 8'd0;
                n_status[FLAG_N] = sum[7];
                // overflow when both inputs agree in sign and the result does not
                n_status[FLAG_V] = !(r_acc[7] ^ i_cmd.data[7]) && (r_acc[7] ^ sum[7]);
            end
            OP_CLC: n_status[FLAG_C] = 1'b0;
            OP_CLD: n_status[FLAG_D] = 1'b0;
            OP_BRANCH: begin
                if (taken) begin
                    n_out.new_pc       = i_cmd.target;
                    n_out.extra_cycles = i_cmd.page_cross ? EXTRA_PAGE : EXTRA_TAKEN;
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
        n_out.accumulator = n_acc;
        n_out.flags       = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 8'd0;
            r_status    <= STATUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_acc    <= n_acc;
                r_status <= n_status;
            end
            if (o_cmd_ready) begin
                r_out_valid <= i_cmd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= n_out;
        end
    end

endmodule

@@ design/mos6502_alu_and_branch.sv @@
// Top level of the 6502 accumulator ALU and conditional branch unit. One
// instruction item is taken every clock cycle unless stalled and gives
// exactly one result item: the accumulator and status byte after the
// instruction, the new program counter and the extra cycle count of a branch.
// The front stage registers the item, decodes it and computes the branch
// target and page crossing; a two-entry queue follows; the back stage applies
// the instruction to the accumulator and status register (reset 0x00 and
// 0x20) and holds the result in an output register. A result passes the front
// register, a queue entry and the output register before it is offered, and
// the back stage's accumulator and status update sustains one item per cycle
// unless the output stalls. Either side may stall independently; the front
// keeps accepting until the queue and front register are full.
module mos6502_alu_and_branch
    import mab_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic b_valid;
    logic b_ready;
    t_cmd b_cmd;

    mab_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    mab_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_cmd   (f_cmd),
        .o_rd_valid (b_valid),
        .i_rd_ready (b_ready),
        .o_rd_cmd   (b_cmd)
    );

    mab_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (b_valid),
        .o_cmd_ready (b_ready),
        .i_cmd       (b_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ tb/sv/testbench.sv @@
// testbench for the 6502 alu and branch block: directed and random items checked against a predictor
module testbench;
    import mab_pkg::*;

    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int         IDLE_PCT    = 32;
    localparam int         STALL_LIMIT = 2000;
    localparam int         TAIL_CYCLES = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // predicted machine state
    logic [7:0] model_acc;
    logic [7:0] model_status;

    t_out_item  expected_q[$];
    t_out_item  want_item;
    int         err_count = 0;
    int         stall_cycles = 0;
    bit         steady = 1'b0;

    mos6502_alu_and_branch i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // executes one instruction on the predicted state and returns its result item
    function automatic t_out_item exec_instr(t_in_item it);
        t_out_item  r;
        logic [7:0] val;
        logic [8:0] sum;
        logic [15:0] tgt;
        logic       take;
        r.new_pc = it.next_pc;
        r.extra_cycles = EXTRA_NONE;
        case (it.mode)
            MODE_AND: begin
                model_acc = model_acc & it.operand;
                model_status[FLAG_Z] = (model_acc == 8'h00);
                model_status[FLAG_N] = model_acc[7];
            end
            MODE_ADC, MODE_SBC: begin
                val = (it.mode == MODE_SBC) ? ~it.operand : it.operand;
                sum = {1'b0, model_acc} + {1'b0, val} + {8'h00, model_status[FLAG_C]};
                model_status[FLAG_C] = sum[8];
                model_status[FLAG_Z] = (sum[7:0] == 8'h00);
                model_status[FLAG_N] = sum[7];
                model_status[FLAG_V] = ~(model_acc[7] ^ val[7]) & (model_acc[7] ^ sum[7]);
                model_acc = sum[7:0];
            end
            MODE_CLC: model_status[FLAG_C] = 1'b0;
            MODE_CLD: model_status[FLAG_D] = 1'b0;
            MODE_BRANCH: begin
                case (it.branch_cond)
                    COND_BPL: take = ~model_status[FLAG_N];
                    COND_BMI: take = model_status[FLAG_N];
                    COND_BVC: take = ~model_status[FLAG_V];
                    COND_BVS: take = model_status[FLAG_V];
                    COND_BCC: take = ~model_status[FLAG_C];
                    COND_BCS: take = model_status[FLAG_C];
                    COND_BNE: take = ~model_status[FLAG_Z];
                    default:  take = model_status[FLAG_Z];
                endcase
                if (take) begin
                    tgt = it.next_pc + {{8{it.rel_offset[7]}}, it.rel_offset};
                    r.new_pc = tgt;
                    r.extra_cycles = (tgt[15:8] != it.next_pc[15:8]) ? EXTRA_PAGE : EXTRA_TAKEN;
                end
            end
            default: ;
        endcase
        r.accumulator = model_acc;
        r.flags = model_status;
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(t_in_item it);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        expected_q.push_back(exec_instr(it));
    endtask

    // stops sending and waits until every predicted result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_in_item make_item(logic [2:0] mode, logic [7:0] operand,
                                           logic [2:0] cond, logic [7:0] offset,
                                           logic [15:0] pc);
        t_in_item it;
        it.mode = mode;
        it.operand = operand;
        it.branch_cond = cond;
        it.rel_offset = offset;
        it.next_pc = pc;
        return it;
    endfunction

    function automatic logic [2:0] pick_mode(int branch_pct);
        int r;
        r = $urandom_range(99);
        if (r < branch_pct) return MODE_BRANCH;
        r = $urandom_range(99);
        if (r < 25) return MODE_AND;
        if (r < 55) return MODE_ADC;
        if (r < 80) return MODE_SBC;
        if (r < 88) return MODE_CLC;
        if (r < 94) return MODE_CLD;
        return $urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7;
    endfunction

    // program counters often sit near a page boundary
    function automatic logic [15:0] pick_pc();
        logic [7:0] lo;
        case ($urandom_range(2))
            0: lo = 8'($urandom_range(0, 3));
            1: lo = 8'hFF - 8'($urandom_range(0, 3));
            default: lo = 8'($urandom);
        endcase
        return {8'($urandom), lo};
    endfunction

    function automatic t_in_item random_item(int branch_pct);
        return make_item(pick_mode(branch_pct), 8'($urandom), 3'($urandom),
                         8'($urandom), pick_pc());
    endfunction

    task automatic test_directed_edges();
        send_item(make_item(MODE_AND, 8'hFF, COND_BPL, 8'h00, 16'h0000));
        send_item(make_item(MODE_ADC, 8'h7F, COND_BMI, 8'h7F, 16'hFFFF));
        send_item(make_item(MODE_ADC, 8'h01, COND_BVC, 8'h80, 16'h0000));
        send_item(make_item(MODE_BRANCH, 8'h00, COND_BMI, 8'h7F, 16'h10F0));
        send_item(make_item(MODE_BRANCH, 8'hFF, COND_BVS, 8'h80, 16'h0000));
        send_item(make_item(MODE_BRANCH, 8'h00, COND_BPL, 8'h10, 16'h2000));
        send_item(make_item(MODE_BRANCH, 8'h00, COND_BVC, 8'hF0, 16'h2000));
        send_item(make_item(MODE_ADC, 8'h80, COND_BEQ, 8'h00, 16'h8000));
        send_item(make_item(MODE_BRANCH, 8'h00, COND_BCS, 8'h00, 16'hFFFF));
        send_item(make_item(MODE_BRANCH, 8'h00, COND_BEQ, 8'h01, 16'hFFFF));
        send_item(make_item(MODE_BRANCH, 8'h00, COND_BCC, 8'h05, 16'h1234));
        send_item(make_item(MODE_BRANCH, 8'h00, COND_BNE, 8'h05, 16'h1234));
        send_item(make_item(MODE_CLC, 8'hFF, COND_BEQ, 8'hFF, 16'hFFFF));
        send_item(make_item(MODE_BRANCH, 8'h00, COND_BCC, 8'hFF, 16'h1200));
        send_item(make_item(MODE_SBC, 8'h00, COND_BPL, 8'h00, 16'h0000));
        send_item(make_item(MODE_BRANCH, 8'h00, COND_BNE, 8'h7F, 16'h00FF));
        send_item(make_item(MODE_SBC, 8'hFF, COND_BPL, 8'h00, 16'h0000));
        send_item(make_item(MODE_SBC, 8'h7F, COND_BPL, 8'h00, 16'h0000));
        send_item(make_item(MODE_AND, 8'h80, COND_BPL, 8'h00, 16'h0000));
        send_item(make_item(MODE_CLD, 8'hAA, COND_BMI, 8'h55, 16'hA5A5));
        // unused modes must leave everything alone
        send_item(make_item(MODE_SPARE6, 8'hFF, COND_BEQ, 8'h80, 16'hFFFF));
        send_item(make_item(MODE_SPARE7, 8'h00, COND_BPL, 8'h7F, 16'h0000));
        send_item(make_item(MODE_BRANCH, 8'h00, COND_BVS, 8'h81, 16'h0180));
        send_item(make_item(MODE_ADC, 8'hFF, COND_BNE, 8'h00, 16'h0000));
        wait_drained();
    endtask

    task automatic test_random_mix();
        repeat (250) send_item(random_item(25));
    endtask

    task automatic test_drain_pause();
        repeat (50) send_item(random_item(30));
        wait_drained();
        repeat (50) send_item(random_item(30));
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (150) send_item(random_item(35));
        steady = 1'b0;
    endtask

    task automatic test_branch_stress();
        repeat (150) send_item(random_item(60));
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out_item);
            end else begin
                want_item = expected_q.pop_front();
                check_field("accumulator", want_item.accumulator, o_out_item.accumulator);
                check_field("flags", want_item.flags, o_out_item.flags);
                check_field("new_pc", want_item.new_pc, o_out_item.new_pc);
                check_field("extra_cycles", want_item.extra_cycles, o_out_item.extra_cycles);
            end
        end
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles = 0;
        else if (i_in_valid || expected_q.size() != 0)
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        model_acc = 8'h00;
        model_status = STATUS_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_edges();
        test_random_mix();
        test_drain_pause();
        test_back_to_back();
        test_branch_stress();
        wait_drained();
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
